[src/ita_pkg.sv]
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, constants and helpers for the integer to ASCII digit
// converter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int BufferChars = 32;
  localparam int PosW        = $clog2(BufferChars);
  localparam int MaxMin      = BufferChars - 1;
  localparam int DecDigits   = 10;
  localparam int DigitW      = 4;
  localparam int BcdW        = DecDigits * DigitW;
  localparam int ValueW      = 32;
  localparam int CntW        = $clog2(ValueW);
  localparam int CharW       = 7;
  localparam int BaseW       = 16;
  localparam int MinW        = 8;

  localparam logic [BaseW-1:0] BaseDefault = 16'd0;
  localparam logic [BaseW-1:0] BaseDec     = 16'd10;
  localparam logic [BaseW-1:0] BaseHex     = 16'd16;

  localparam logic [CharW-1:0] CharZero   = 7'h30;
  localparam logic [CharW-1:0] CharNine   = 7'h39;
  localparam logic [CharW-1:0] CharUpperA = 7'h41;
  localparam logic [CharW-1:0] CharUpperF = 7'h46;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_ERR  = 4'b1000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dbl_status_t;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {{(CharW-DigitW){1'b0}}, d};
    if (d < DigitW'(10)) begin
      return CharZero + dx;
    end else begin
      return CharUpperA + dx - CharW'(10);
    end
  endfunction

endpackage

[src/integer_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts a 32-bit unsigned value to upper-case ASCII digits, base 10 or 16,
// most significant first, with leading '0' padding to a minimum count.
// ----------------------------------------------------------------------------
// sequence: a hex request goes from idle straight to the digit stage, a decimal
//   one first passes through the bit-serial bcd converter; that stage steps one
//   position per cycle while out is not stalled, from max(min,10)-1 down to 0,
//   skipping leading zeros; throughput: one request at a time, a new one is taken
//   only once the last character or error result of the previous one is registered
// reset: synchronous, returns to idle and drops any pending result
module integer_to_ascii_digits import ita_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ValueW-1:0] number_value,
  input  logic [31:0]       format_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CharW-1:0]  char_code,
  output logic              is_last,
  output logic              bad_format
);

  state_t            state;
  logic [BcdW-1:0]   digits;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   min_cnt;
  logic              started;

  logic [BaseW-1:0]  base;
  logic              is_dec;
  logic              is_hex;
  logic [PosW-1:0]   min_next;
  logic [PosW-1:0]   pos_next;
  logic              accept;
  logic              out_free;
  logic [DigitW-1:0] cur_digit;
  logic              emit_now;
  logic              in_range;

  dbl_status_t       dbl_st;
  logic [BcdW-1:0]   dbl_bcd;

  assign base     = format_word[31:16];
  assign is_dec   = (base == BaseDefault) || (base == BaseDec);
  assign is_hex   = (base == BaseHex);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (format_word[MinW-1:0] > MinW'(MaxMin)) begin
      min_next = PosW'(MaxMin);
    end else begin
      min_next = format_word[PosW-1:0];
    end
    if (min_next > PosW'(DecDigits)) begin
      pos_next = min_next - PosW'(1);
    end else begin
      pos_next = PosW'(DecDigits - 1);
    end
  end

  // positions above the ten stored digits are always zero
  assign in_range  = (pos < PosW'(DecDigits));
  assign cur_digit = in_range ? digits[BcdW-1 -: DigitW] : '0;
  assign emit_now  = started || (cur_digit != '0) || (pos < min_cnt) ||
                     (pos == '0);

  ita_dbl u_dbl (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && is_dec),
    .value  (number_value),
    .status (dbl_st),
    .bcd    (dbl_bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            started <= 1'b0;
            if (is_dec) begin
              state <= ST_CONV;
            end else if (is_hex) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_ERR;
            end
          end
        end
        ST_CONV: begin
          if (dbl_st.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (emit_now) begin
              out_valid <= 1'b1;
              started   <= 1'b1;
            end else begin
              out_valid <= 1'b0;
            end
            if (pos == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload side: digit shift register, position counter, result register
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          digits  <= {{(BcdW-ValueW){1'b0}}, number_value};
          pos     <= pos_next;
          min_cnt <= min_next;
        end
      end
      ST_CONV: begin
        if (dbl_st.done) begin
          digits <= dbl_bcd;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (in_range) begin
            digits <= {digits[BcdW-DigitW-1:0], {DigitW{1'b0}}};
          end
          if (emit_now) begin
            char_code  <= digit_char(cur_digit);
            is_last    <= (pos == '0);
            bad_format <= 1'b0;
          end
          pos <= pos - PosW'(1);
        end
      end
      ST_ERR: begin
        if (out_free) begin
          char_code  <= '0;
          is_last    <= 1'b1;
          bad_format <= 1'b1;
        end
      end
      default: begin
        pos <= '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_format |-> is_last && char_code == '0)
    else $error("error result malformed");
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_format |->
      (char_code >= CharZero && char_code <= CharNine) ||
      (char_code >= CharUpperA && char_code <= CharUpperF))
    else $error("character outside digit set");
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    dbl_st.done |-> state == ST_CONV)
    else $error("conversion finished outside conversion state");
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request taken while another is in progress");
`endif

endmodule

[src/ita_dbl.sv]
// ----------------------------------------------------------------------------
// ita_dbl
// Bit-serial binary to BCD converter: shift-and-add-three, one value bit per
// cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ita_dbl import ita_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ValueW-1:0] value,
  output dbl_status_t       status,
  output logic [BcdW-1:0]   bcd
);

  logic [ValueW-1:0] sh;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic              done;
  logic [BcdW-1:0]   adj;

  // each bcd digit gets +3 when 5 or more, ahead of the shift
  always_comb begin
    for (int k = 0; k < DecDigits; k++) begin
      if (bcd[k*DigitW +: DigitW] >= DigitW'(5)) begin
        adj[k*DigitW +: DigitW] = bcd[k*DigitW +: DigitW] + DigitW'(3);
      end else begin
        adj[k*DigitW +: DigitW] = bcd[k*DigitW +: DigitW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntW'(ValueW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= value;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[BcdW-2:0], sh[ValueW-1]};
      sh  <= {sh[ValueW-2:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("conversion done without a running conversion");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == '0)
    else $error("start did not launch a conversion");
  a_busy_clears_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("done raised while converting");
`endif

endmodule

[bench/tb_integer_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Self-checking bench for the integer to ASCII digit converter. Requests go
// in from a queue through a clocked driver with random gaps. Every accepted
// request is run through a behavioural digit predictor, and a clocked monitor
// with random back-pressure checks each character against the oldest one due.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits;
  import ita_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandomReqs = 310;
  localparam int MaxReports = 10;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [31:0]       fmt;
  } conv_request_t;

  typedef struct {
    logic [CharW-1:0] code;
    logic             last;
    logic             bad;
  } ascii_char_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ValueW-1:0] number_value = '0;
  logic [31:0]       format_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CharW-1:0]  char_code;
  logic              is_last;
  logic              bad_format;

  conv_request_t conv_requests[$];
  ascii_char_t   chars_due[$];

  int unsigned src_wait, src_burst, snk_wait, snk_burst;
  int unsigned dec_reqs, hex_reqs, bad_reqs, chars_seen, error_count;
  int unsigned cycle_count;

  integer_to_ascii_digits uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .number_value(number_value),
    .format_word (format_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .is_last     (is_last),
    .bad_format  (bad_format)
  );

  always #5 clk = ~clk;

  // works out the characters one request should produce
  function automatic void predict_digits(input logic [ValueW-1:0] val,
                                         input logic [31:0] fmt);
    logic [BaseW-1:0] base_field;
    int unsigned      radix, min_len, d;
    logic [ValueW-1:0] rest;
    logic [CharW-1:0] digits[$];
    ascii_char_t      c;
    base_field = fmt[31:16];
    radix = (base_field == BaseDefault) ? 10 : int'(base_field);
    if (radix != 10 && radix != 16) begin
      bad_reqs++;
      c.code = '0;
      c.last = 1'b1;
      c.bad  = 1'b1;
      chars_due.push_back(c);
      return;
    end
    if (radix == 10) dec_reqs++;
    else hex_reqs++;
    min_len = int'(fmt[MinW-1:0]);
    if (min_len > MaxMin) min_len = MaxMin;
    rest = val;
    do begin
      d = rest % radix;
      digits.push_front((d < 10) ? CharZero + CharW'(d) : CharUpperA + CharW'(d - 10));
      rest = rest / radix;
    end while (rest != 0);
    while (digits.size() < min_len) digits.push_front(CharZero);
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      c.bad  = 1'b0;
      chars_due.push_back(c);
    end
  endfunction

  function automatic void add_request(input logic [ValueW-1:0] val,
                                      input logic [BaseW-1:0] base,
                                      input logic [7:0] spare,
                                      input logic [MinW-1:0] min_len);
    conv_request_t r;
    r.value = val;
    r.fmt   = {base, spare, min_len};
    conv_requests.push_back(r);
  endfunction

  // request driver
  always @(posedge clk) begin
    logic          take;
    conv_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      src_wait = 0;
      src_burst = 0;
    end else begin
      take = in_valid && !in_stall;
      if (take) predict_digits(number_value, format_word);
      if (!in_valid || take) begin
        if (src_wait > 0) begin
          src_wait--;
          in_valid <= 1'b0;
        end else if (conv_requests.size() > 0) begin
          req = conv_requests.pop_front();
          in_valid     <= 1'b1;
          number_value <= req.value;
          format_word  <= req.fmt;
          // gap before the next request, with runs of back-to-back requests
          if (src_burst > 0) begin
            src_burst--;
            src_wait = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            src_burst = $urandom_range(5, 25);
            src_wait = 0;
          end else begin
            src_wait = $urandom_range(0, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // character monitor and back-pressure
  always @(posedge clk) begin
    ascii_char_t want;
    if (rst) begin
      out_stall <= 1'b0;
      snk_wait = 0;
      snk_burst = 0;
    end else begin
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (chars_due.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("[%0d] unexpected character: code %h last %b bad %b",
                     cycle_count, char_code, is_last, bad_format);
        end else begin
          want = chars_due.pop_front();
          if (char_code !== want.code || is_last !== want.last ||
              bad_format !== want.bad) begin
            error_count++;
            if (error_count <= MaxReports)
              $display("[%0d] mismatch: code %h/%h last %b/%b bad %b/%b (want/got)",
                       cycle_count, want.code, char_code, want.last, is_last,
                       want.bad, bad_format);
          end
        end
        if (snk_burst > 0) begin
          snk_burst--;
          snk_wait = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          snk_burst = $urandom_range(10, 60);
          snk_wait = 0;
        end else begin
          snk_wait = $urandom_range(0, 15);
        end
      end else if (snk_wait > 0) begin
        snk_wait--;
      end
      out_stall <= (snk_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timed out after %0d cycles, %0d characters still due",
               cycle_count, chars_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [BaseW-1:0] base;
    logic [ValueW-1:0] val;
    logic [MinW-1:0]  min_len;
    int unsigned      pick;

    // corner requests
    add_request(32'd0, BaseDefault, 8'h00, 8'd0);
    add_request(32'd0, BaseHex, 8'h00, 8'd0);
    add_request(32'hFFFF_FFFF, BaseDefault, 8'h00, 8'd0);
    add_request(32'hFFFF_FFFF, BaseHex, 8'h00, 8'd0);
    add_request(32'hFFFF_FFFF, BaseDec, 8'h00, 8'd31);
    add_request(32'd1, BaseDec, 8'h00, 8'hFF);
    add_request(32'hABCD_EF01, BaseHex, 8'h00, 8'd32);
    add_request(32'h1234_5678, BaseHex, 8'h00, 8'd31);
    add_request(32'd1000000000, BaseDefault, 8'h00, 8'd10);
    add_request(32'd999999999, BaseDec, 8'h00, 8'd11);
    add_request(32'h8000_0000, BaseHex, 8'hFF, 8'd9);
    add_request(32'hFEDC_BA98, BaseHex, 8'h00, 8'd1);
    add_request(32'd9, BaseDefault, 8'hA5, 8'd1);
    add_request(32'd10, BaseDec, 8'h5A, 8'd2);
    add_request(32'd15, BaseHex, 8'h00, 8'd0);
    add_request(32'd0, BaseDec, 8'h00, 8'd31);
    // unsupported bases, including ones next to the legal values
    add_request(32'd123, 16'd1, 8'h00, 8'd0);
    add_request(32'd123, 16'd2, 8'h00, 8'd5);
    add_request(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);
    add_request(32'd77, 16'd9, 8'h00, 8'd3);
    add_request(32'd77, 16'd11, 8'h00, 8'd0);
    add_request(32'd77, 16'd15, 8'h00, 8'd0);
    add_request(32'd77, 16'd17, 8'h00, 8'd31);
    add_request(32'd77, 16'h8000, 8'h00, 8'd0);

    repeat (RandomReqs) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) base = BaseDefault;
      else if (pick < 55) base = BaseDec;
      else if (pick < 85) base = BaseHex;
      else begin
        do base = BaseW'($urandom_range(1, 16'hFFFF));
        while (base == BaseDec || base == BaseHex);
      end
      case ($urandom_range(0, 3))
        0: val = $urandom;
        1: val = $urandom >> $urandom_range(0, 31);
        2: val = $urandom_range(0, 99);
        default: val = $urandom_range(0, 15) << (4 * $urandom_range(0, 7));
      endcase
      // mostly short paddings, a few long or clamped ones
      if ($urandom_range(0, 7) == 0) min_len = MinW'($urandom_range(0, 255));
      else min_len = MinW'($urandom_range(0, 12));
      add_request(val, base, 8'($urandom), min_len);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (conv_requests.size() > 0 || in_valid || chars_due.size() > 0);
    repeat (100) @(negedge clk);

    $display("requests converted: %0d decimal, %0d hex, %0d unsupported base",
             dec_reqs, hex_reqs, bad_reqs);
    $display("characters checked: %0d, mismatches: %0d", chars_seen, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/ita_pkg.sv
src/ita_dbl.sv
src/integer_to_ascii_digits.sv
bench/tb_integer_to_ascii_digits.sv
